[sv/hrlp_pkg.sv]
// hrlp_pkg: shared types and constants for the HSV/RGB LED pulse encoder.
// No dependencies; used by every module of the block.
`default_nettype none

package hrlp_pkg;

    localparam logic [1:0] CFG_ONE_DUTY  = 2'd0;
    localparam logic [1:0] CFG_ZERO_DUTY = 2'd1;
    localparam logic [1:0] CFG_LED_COUNT = 2'd2;

    localparam logic CMD_RGB = 1'b0;
    localparam logic CMD_HSV = 1'b1;

    localparam logic [6:0] PCT_MAX  = 7'd100;
    localparam logic [4:0] LAST_BIT = 5'd23;
    localparam logic [8:0] LED_COUNT_RST = 9'd256;

    // floor(x/360) = (x*HUE_RECIP) >> HUE_SHIFT, exact for x < 2^16
    localparam logic [32:0] HUE_RECIP = 33'd93207;
    localparam int          HUE_SHIFT = 25;
    // floor(x/100) for x <= 25500
    localparam logic [31:0] PCT_RECIP = 32'd41944;
    localparam int          PCT_SHIFT = 22;
    // floor(x/60) for x < 360
    localparam logic [19:0] SEC_RECIP = 20'd1093;
    localparam int          SEC_SHIFT = 16;
    // floor(x/60) for x <= 15045
    localparam logic [31:0] ADJ_RECIP = 32'd17477;
    localparam int          ADJ_SHIFT = 20;

    localparam int FRONT_STAGES = 8;
    localparam int QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic [7:0]  idx;
        logic        cmd;
        logic [23:0] grb;
    } t_tag;

    typedef struct packed {
        logic [7:0]  idx;
        logic [23:0] grb;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

`default_nettype wire

[sv/hsv_rgb_led_pulse_encoder.sv]
// hsv_rgb_led_pulse_encoder: top level; configuration registers, front
// converter, color queue and duty-word serializer. Depends on hrlp_pkg.
//
//  channel  | ports                                            | transaction
//  ---------+--------------------------------------------------+---------------------
//  command  | i_start, o_busy, i_cmd .. i_brightness          | start && !busy
//  result   | o_strobe, o_out_led, o_bit_position, o_duty, o_last | o_strobe
//  config   | i_cfg_we, i_cfg_index, i_cfg_data                | i_cfg_we
//
// Each in-range LED gives 24 words, one per cycle, set by the serializer.
// The front pipeline feeds a 4-entry queue that lets commands arrive while
// words go out, so the serializer can send the words of queued LEDs back to back.
// An out-of-range LED index is accepted but yields nothing.
// Reset is synchronous, active low; o_busy rises when the queue is full
// and a converted color waits at the last front stage.
`default_nettype none

module hsv_rgb_led_pulse_encoder #(
    parameter int MAX_LEDS = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    output logic             o_busy,
    input  wire logic        i_cmd,
    input  wire logic [7:0]  i_led_index,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [15:0] i_hue,
    input  wire logic [6:0]  i_saturation,
    input  wire logic [6:0]  i_brightness,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output logic             o_strobe,
    output logic [7:0]       o_out_led,
    output logic [4:0]       o_bit_position,
    output logic [15:0]      o_duty,
    output logic             o_last
);

    logic [15:0] r_one_duty;
    logic [15:0] r_zero_duty;
    logic [8:0]  r_led_count;

    hrlp_pkg::t_qstat qstat;
    hrlp_pkg::t_entry push_ent;
    hrlp_pkg::t_entry head_ent;
    logic             push;
    logic             pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_one_duty  <= '0;
            r_zero_duty <= '0;
            r_led_count <= hrlp_pkg::LED_COUNT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hrlp_pkg::CFG_ONE_DUTY:  r_one_duty  <= i_cfg_data;
                hrlp_pkg::CFG_ZERO_DUTY: r_zero_duty <= i_cfg_data;
                hrlp_pkg::CFG_LED_COUNT: r_led_count <= i_cfg_data[8:0];
                default: ;
            endcase
        end
    end

    hrlp_front #(
        .MAX_LEDS(MAX_LEDS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_cmd        (i_cmd),
        .i_led_index  (i_led_index),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .i_hue        (i_hue),
        .i_saturation (i_saturation),
        .i_brightness (i_brightness),
        .i_led_count  (r_led_count),
        .i_qstat      (qstat),
        .o_push       (push),
        .o_entry      (push_ent)
    );

    hrlp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_ent),
        .i_pop   (pop),
        .o_entry (head_ent),
        .o_stat  (qstat)
    );

    hrlp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_qstat        (qstat),
        .i_entry        (head_ent),
        .o_pop          (pop),
        .i_one_duty     (r_one_duty),
        .i_zero_duty    (r_zero_duty),
        .o_strobe       (o_strobe),
        .o_out_led      (o_out_led),
        .o_bit_position (o_bit_position),
        .o_duty         (o_duty),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

[sv/hrlp_front.sv]
// hrlp_front: accepts commands, drops out-of-range LEDs, converts HSV to RGB
// in an 8-stage pipeline. Depends on hrlp_pkg.
`default_nettype none

module hrlp_front #(
    parameter int MAX_LEDS = 256
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    output logic                        o_busy,
    input  wire logic                   i_cmd,
    input  wire logic [7:0]             i_led_index,
    input  wire logic [7:0]             i_red,
    input  wire logic [7:0]             i_green,
    input  wire logic [7:0]             i_blue,
    input  wire logic [15:0]            i_hue,
    input  wire logic [6:0]             i_saturation,
    input  wire logic [6:0]             i_brightness,
    input  wire logic [8:0]             i_led_count,
    input  wire hrlp_pkg::t_qstat       i_qstat,
    output logic                        o_push,
    output hrlp_pkg::t_entry            o_entry
);

    localparam int NS = hrlp_pkg::FRONT_STAGES;

    logic [NS-1:0] r_vld;
    logic          adv;
    logic          take;
    logic          in_range;

    hrlp_pkg::t_tag r_a_tag, r_b_tag, r_c_tag, r_d_tag, r_e_tag, r_f_tag, r_g_tag;
    logic [15:0] r_a_h, r_b_h;
    logic [6:0]  r_a_s, r_b_s, r_c_s;
    logic [6:0]  r_a_v;
    logic [14:0] r_b_vx;
    logic [7:0]  r_b_q;
    logic [7:0]  r_c_mx, r_d_mx, r_e_mx, r_f_mx, r_g_mx;
    logic [8:0]  r_c_hi, r_d_hi;
    logic [14:0] r_d_p;
    logic [2:0]  r_d_sec, r_e_sec, r_f_sec, r_g_sec;
    logic [7:0]  r_e_mn, r_f_mn, r_g_mn;
    logic [5:0]  r_e_off;
    logic [13:0] r_f_prod;
    logic [7:0]  r_g_adj;
    hrlp_pkg::t_entry r_h_ent;

    logic [32:0] hue_prod;
    logic [31:0] mx_prod;
    logic [15:0] hi_full;
    logic [19:0] sec_prod;
    logic [31:0] mn_prod;
    logic [8:0]  off_full;
    logic [31:0] adj_prod;
    logic [7:0]  ch_r, ch_g, ch_b;
    logic [7:0]  mx_adj, mn_adj;

    assign adv      = !(r_vld[NS-1] && i_qstat.full);
    assign o_busy   = !adv;
    assign in_range = ({1'b0, i_led_index} < i_led_count)
                      && (32'(i_led_index) < MAX_LEDS);
    assign take     = i_start && adv && in_range;
    assign o_push   = r_vld[NS-1] && !i_qstat.full;
    assign o_entry  = r_h_ent;

    assign hue_prod = 33'(r_a_h) * hrlp_pkg::HUE_RECIP;
    assign mx_prod  = 32'(r_b_vx) * hrlp_pkg::PCT_RECIP;
    assign hi_full  = r_b_h - 16'(r_b_q) * 16'd360;
    assign sec_prod = 20'(r_c_hi) * hrlp_pkg::SEC_RECIP;
    assign mn_prod  = 32'(r_d_p) * hrlp_pkg::PCT_RECIP;
    assign off_full = r_d_hi - 9'(r_d_sec) * 9'd60;
    assign adj_prod = 32'(r_f_prod) * hrlp_pkg::ADJ_RECIP;
    assign mx_adj   = r_g_mx - r_g_adj;
    assign mn_adj   = r_g_mn + r_g_adj;

    always_comb begin
        unique case (r_g_sec)
            3'd0: begin ch_r = r_g_mx; ch_g = mn_adj; ch_b = r_g_mn; end
            3'd1: begin ch_r = mx_adj; ch_g = r_g_mx; ch_b = r_g_mn; end
            3'd2: begin ch_r = r_g_mn; ch_g = r_g_mx; ch_b = mn_adj; end
            3'd3: begin ch_r = r_g_mn; ch_g = mx_adj; ch_b = r_g_mx; end
            3'd4: begin ch_r = mn_adj; ch_g = r_g_mn; ch_b = r_g_mx; end
            default: begin ch_r = r_g_mx; ch_g = r_g_mn; ch_b = mx_adj; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_tag <= '{idx: i_led_index, cmd: i_cmd, grb: {i_green, i_red, i_blue}};
            r_a_h   <= i_hue;
            r_a_s   <= (i_saturation > hrlp_pkg::PCT_MAX) ? hrlp_pkg::PCT_MAX : i_saturation;
            r_a_v   <= (i_brightness > hrlp_pkg::PCT_MAX) ? hrlp_pkg::PCT_MAX : i_brightness;

            r_b_tag <= r_a_tag;
            r_b_h   <= r_a_h;
            r_b_s   <= r_a_s;
            r_b_vx  <= 15'(r_a_v) * 15'd255;
            r_b_q   <= 8'(hue_prod >> hrlp_pkg::HUE_SHIFT);

            r_c_tag <= r_b_tag;
            r_c_s   <= r_b_s;
            r_c_mx  <= 8'(mx_prod >> hrlp_pkg::PCT_SHIFT);
            r_c_hi  <= hi_full[8:0];

            r_d_tag <= r_c_tag;
            r_d_mx  <= r_c_mx;
            r_d_hi  <= r_c_hi;
            r_d_p   <= 15'(r_c_mx) * 15'(hrlp_pkg::PCT_MAX - r_c_s);
            r_d_sec <= 3'(sec_prod >> hrlp_pkg::SEC_SHIFT);

            r_e_tag <= r_d_tag;
            r_e_mx  <= r_d_mx;
            r_e_sec <= r_d_sec;
            r_e_mn  <= 8'(mn_prod >> hrlp_pkg::PCT_SHIFT);
            r_e_off <= off_full[5:0];

            r_f_tag  <= r_e_tag;
            r_f_mx   <= r_e_mx;
            r_f_mn   <= r_e_mn;
            r_f_sec  <= r_e_sec;
            r_f_prod <= 14'(r_e_mx - r_e_mn) * 14'(r_e_off);

            r_g_tag <= r_f_tag;
            r_g_mx  <= r_f_mx;
            r_g_mn  <= r_f_mn;
            r_g_sec <= r_f_sec;
            r_g_adj <= 8'(adj_prod >> hrlp_pkg::ADJ_SHIFT);

            r_h_ent.idx <= r_g_tag.idx;
            r_h_ent.grb <= (r_g_tag.cmd == hrlp_pkg::CMD_HSV) ? {ch_g, ch_r, ch_b}
                                                              : r_g_tag.grb;
        end
    end

endmodule

`default_nettype wire

[sv/hrlp_queue.sv]
// hrlp_queue: small FIFO of converted colors between front and back.
// Depends on hrlp_pkg.
`default_nettype none

module hrlp_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire hrlp_pkg::t_entry i_entry,
    input  wire logic             i_pop,
    output hrlp_pkg::t_entry      o_entry,
    output hrlp_pkg::t_qstat      o_stat
);

    localparam int D  = hrlp_pkg::QUEUE_DEPTH;
    localparam int AW = $clog2(D);
    localparam int CW = $clog2(D + 1);

    hrlp_pkg::t_entry r_mem [D];
    logic [AW-1:0] r_wp, r_rp;
    logic [CW-1:0] r_cnt;

    assign o_stat.full  = (r_cnt == CW'(D));
    assign o_stat.empty = (r_cnt == '0);
    assign o_entry      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= (r_wp == AW'(D - 1)) ? '0 : r_wp + AW'(1);
            if (i_pop)  r_rp <= (r_rp == AW'(D - 1)) ? '0 : r_rp + AW'(1);
            if (i_push && !i_pop) r_cnt <= r_cnt + CW'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_stat.full) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty) else $error("pop from empty queue");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_cnt == $past(r_cnt) + CW'(1)))
        else $error("queue count did not advance");

endmodule

`default_nettype wire

[sv/hrlp_back.sv]
// hrlp_back: serializes one queued color into 24 duty words, MSB first.
// Depends on hrlp_pkg.
`default_nettype none

module hrlp_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire hrlp_pkg::t_qstat i_qstat,
    input  wire hrlp_pkg::t_entry i_entry,
    output logic                  o_pop,
    input  wire logic [15:0]      i_one_duty,
    input  wire logic [15:0]      i_zero_duty,
    output logic                  o_strobe,
    output logic [7:0]            o_out_led,
    output logic [4:0]            o_bit_position,
    output logic [15:0]           o_duty,
    output logic                  o_last
);

    logic        r_act;
    logic [4:0]  r_bit;
    logic [7:0]  r_idx;
    logic [23:0] r_sh;
    logic        at_last;

    assign at_last = (r_bit == hrlp_pkg::LAST_BIT);
    assign o_pop   = !i_qstat.empty && (!r_act || at_last);

    assign o_strobe       = r_act;
    assign o_out_led      = r_idx;
    assign o_bit_position = r_bit;
    assign o_duty         = r_sh[23] ? i_one_duty : i_zero_duty;
    assign o_last         = r_act && at_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act <= 1'b0;
            r_bit <= '0;
        end else if (o_pop) begin
            r_act <= 1'b1;
            r_bit <= '0;
        end else if (r_act) begin
            if (at_last) r_act <= 1'b0;
            else         r_bit <= r_bit + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_idx <= i_entry.idx;
            r_sh  <= i_entry.grb;
        end else if (r_act) begin
            r_sh  <= {r_sh[22:0], 1'b0};
        end
    end

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_act && !at_last) |=> (r_act && r_bit == $past(r_bit) + 5'd1))
        else $error("bit counter skipped");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_act |-> (r_bit <= hrlp_pkg::LAST_BIT)) else $error("bit position out of range");
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_qstat.empty && !r_act) |=> (r_act && r_bit == 5'd0))
        else $error("queued color not started");

endmodule

`default_nettype wire

[tb/hsv_rgb_led_pulse_encoder_test.sv]
// Testbench for hsv_rgb_led_pulse_encoder: drives set-color commands and
// config writes, predicts the 24 duty words per in-range LED, checks each.
// Depends on hrlp_pkg and the hsv_rgb_led_pulse_encoder RTL.
`timescale 1ns / 100ps

module hsv_rgb_led_pulse_encoder_test;

    localparam logic [1:0] CFG_UNUSED  = 2'd3;
    localparam int FLUSH_CYCLES   = 64;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_GAP        = 50;
    localparam int REPORT_LIMIT   = 10;
    localparam int RANDOM_PER_PHASE = 25;

    typedef struct packed {
        logic [7:0]  led;
        logic [4:0]  pos;
        logic [15:0] duty;
        logic        last;
    } t_duty_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cmd;
    logic [7:0]  i_led_index;
    logic [7:0]  i_red;
    logic [7:0]  i_green;
    logic [7:0]  i_blue;
    logic [15:0] i_hue;
    logic [6:0]  i_saturation;
    logic [6:0]  i_brightness;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_strobe;
    logic [7:0]  o_out_led;
    logic [4:0]  o_bit_position;
    logic [15:0] o_duty;
    logic        o_last;

    logic [15:0] one_duty_q;
    logic [15:0] zero_duty_q;
    logic [8:0]  led_count_q;

    t_duty_word pending_words[$];
    int mismatches  = 0;
    int idle_pct    = 0;
    int quiet_cycles = 0;

    hsv_rgb_led_pulse_encoder #(.MAX_LEDS(256)) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_cmd          (i_cmd),
        .i_led_index    (i_led_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_hue          (i_hue),
        .i_saturation   (i_saturation),
        .i_brightness   (i_brightness),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_out_led      (o_out_led),
        .o_bit_position (o_bit_position),
        .o_duty         (o_duty),
        .o_last         (o_last)
    );

    always #5 i_clk = ~i_clk;

    // green, red, blue packed as sent on the wire
    function automatic logic [23:0] led_grb(input logic cmd, input logic [7:0] r,
                                            input logic [7:0] g, input logic [7:0] b,
                                            input logic [15:0] hue, input logic [6:0] sat,
                                            input logic [6:0] bri);
        int unsigned h, s, v, sector, off, mx, mn, adj, rr, gg, bb;
        if (cmd == hrlp_pkg::CMD_RGB) return {g, r, b};
        s = (sat > hrlp_pkg::PCT_MAX) ? hrlp_pkg::PCT_MAX : sat;
        v = (bri > hrlp_pkg::PCT_MAX) ? hrlp_pkg::PCT_MAX : bri;
        h = hue % 360;
        sector = h / 60;
        off = h % 60;
        mx = (v * 255) / 100;
        mn = (mx * (100 - s)) / 100;
        adj = ((mx - mn) * off) / 60;
        case (sector)
            0: begin rr = mx;       gg = mn + adj; bb = mn;       end
            1: begin rr = mx - adj; gg = mx;       bb = mn;       end
            2: begin rr = mn;       gg = mx;       bb = mn + adj; end
            3: begin rr = mn;       gg = mx - adj; bb = mx;       end
            4: begin rr = mn + adj; gg = mn;       bb = mx;       end
            default: begin rr = mx; gg = mn;       bb = mx - adj; end
        endcase
        return {gg[7:0], rr[7:0], bb[7:0]};
    endfunction

    task automatic queue_led_words(input logic [7:0] idx, input logic [23:0] grb);
        t_duty_word w;
        if (idx >= led_count_q) return;
        for (int k = 0; k < 24; k++) begin
            w.led  = idx;
            w.pos  = 5'(k);
            w.duty = grb[23 - k] ? one_duty_q : zero_duty_q;
            w.last = (5'(k) == hrlp_pkg::LAST_BIT);
            pending_words.push_back(w);
        end
    endtask

    task automatic send_led(input logic cmd, input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b,
                            input logic [15:0] hue, input logic [6:0] sat,
                            input logic [6:0] bri);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start      <= 1'b1;
        i_cmd        <= cmd;
        i_led_index  <= idx;
        i_red        <= r;
        i_green      <= g;
        i_blue       <= b;
        i_hue        <= hue;
        i_saturation <= sat;
        i_brightness <= bri;
        do @(posedge i_clk); while (o_busy);
        queue_led_words(idx, led_grb(cmd, r, g, b, hue, sat, bri));
    endtask

    task automatic send_rgb(input logic [7:0] idx, input logic [7:0] r,
                            input logic [7:0] g, input logic [7:0] b);
        send_led(hrlp_pkg::CMD_RGB, idx, r, g, b, 16'($urandom), 7'($urandom),
                 7'($urandom));
    endtask

    task automatic send_hsv(input logic [7:0] idx, input logic [15:0] hue,
                            input logic [6:0] sat, input logic [6:0] bri);
        send_led(hrlp_pkg::CMD_HSV, idx, 8'($urandom), 8'($urandom), 8'($urandom),
                 hue, sat, bri);
    endtask

    task automatic drain;
        i_start <= 1'b0;
        while (pending_words.size() != 0) @(posedge i_clk);
        repeat (FLUSH_CYCLES) @(posedge i_clk);
    endtask

    // writes all registers plus the unused index, which must be ignored
    task automatic set_config(input logic [15:0] one, input logic [15:0] zero,
                              input logic [8:0] count);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= hrlp_pkg::CFG_ONE_DUTY;
        i_cfg_data  <= one;
        @(posedge i_clk);
        i_cfg_index <= hrlp_pkg::CFG_ZERO_DUTY;
        i_cfg_data  <= zero;
        @(posedge i_clk);
        i_cfg_index <= hrlp_pkg::CFG_LED_COUNT;
        i_cfg_data  <= {7'd0, count};
        @(posedge i_clk);
        i_cfg_index <= CFG_UNUSED;
        i_cfg_data  <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        one_duty_q  = one;
        zero_duty_q = zero;
        led_count_q = count;
    endtask

    task automatic test_reset_values;
        idle_pct = 0;
        send_rgb(8'd255, 8'hA5, 8'h5A, 8'hC3);
        send_hsv(8'd17, 16'd0, 7'd100, 7'd100);
        drain();
    endtask

    task automatic test_rgb_extremes;
        set_config(16'hFFFF, 16'h0000, hrlp_pkg::LED_COUNT_RST);
        send_rgb(8'd0, 8'h00, 8'h00, 8'h00);
        send_rgb(8'd255, 8'hFF, 8'hFF, 8'hFF);
        send_rgb(8'h55, 8'h55, 8'hAA, 8'h0F);
        drain();
        set_config(16'h0000, 16'hFFFF, hrlp_pkg::LED_COUNT_RST);
        send_rgb(8'hAA, 8'hFF, 8'h00, 8'hFF);
        drain();
    endtask

    task automatic test_hsv_sectors;
        set_config(16'd60, 16'd30, hrlp_pkg::LED_COUNT_RST);
        for (int k = 0; k < 6; k++) send_hsv(8'(k), 16'(30 + 60 * k), 7'd75, 7'd90);
        send_hsv(8'd6, 16'd359, 7'd100, 7'd100);
        send_hsv(8'd7, 16'd360, 7'd0, 7'd100);
        send_hsv(8'd8, 16'hFFFF, 7'd127, 7'd127);
        send_hsv(8'd9, 16'd200, 7'd50, 7'd0);
        drain();
    endtask

    task automatic test_chain_length;
        set_config(16'h1234, 16'h4321, 9'd0);
        send_rgb(8'd0, 8'h12, 8'h34, 8'h56);
        send_rgb(8'd255, 8'h12, 8'h34, 8'h56);
        drain();
        set_config(16'h00FF, 16'hFF00, 9'd1);
        send_rgb(8'd0, 8'h81, 8'h42, 8'h24);
        send_rgb(8'd1, 8'h81, 8'h42, 8'h24);
        drain();
        set_config(16'hBEEF, 16'h0001, 9'd255);
        send_hsv(8'd254, 16'd100, 7'd101, 7'd60);
        send_rgb(8'd255, 8'h99, 8'h66, 8'h33);
        drain();
    endtask

    task automatic test_random_traffic;
        int phase_idle[4] = '{0, 86, 0, 10};
        logic [8:0] count;
        logic [7:0] idx;
        foreach (phase_idle[p]) begin
            count = ($urandom_range(2) == 0) ? 9'($urandom_range(256))
                                              : hrlp_pkg::LED_COUNT_RST;
            set_config(16'($urandom), 16'($urandom), count);
            idle_pct = phase_idle[p];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (led_count_q == 0 || $urandom_range(7) == 0)
                    idx = 8'($urandom);
                else
                    idx = 8'($urandom_range(led_count_q - 1));
                send_led(1'($urandom), idx, 8'($urandom), 8'($urandom), 8'($urandom),
                         16'($urandom), 7'($urandom), 7'($urandom));
            end
            drain();
        end
    endtask

    always @(posedge i_clk) begin : check_words
        t_duty_word got, want;
        if (i_rst_n && o_strobe) begin
            got = '{o_out_led, o_bit_position, o_duty, o_last};
            if (pending_words.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected word: led %0d pos %0d duty %h last %b",
                             got.led, got.pos, got.duty, got.last);
            end else begin
                want = pending_words.pop_front();
                if (got.led !== want.led || got.pos !== want.pos ||
                    got.duty !== want.duty || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: exp %0d/%0d/%h/%b got %0d/%0d/%h/%b",
                                 want.led, want.pos, want.duty, want.last,
                                 got.led, got.pos, got.duty, got.last);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_start      <= 1'b0;
        i_cmd        <= hrlp_pkg::CMD_RGB;
        i_led_index  <= '0;
        i_red        <= '0;
        i_green      <= '0;
        i_blue       <= '0;
        i_hue        <= '0;
        i_saturation <= '0;
        i_brightness <= '0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= hrlp_pkg::CFG_ONE_DUTY;
        i_cfg_data   <= '0;
        one_duty_q   = '0;
        zero_duty_q  = '0;
        led_count_q  = hrlp_pkg::LED_COUNT_RST;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_rgb_extremes();
        test_hsv_sectors();
        test_chain_length();
        test_random_traffic();

        if (mismatches == 0 && pending_words.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[sim.f]
sv/hrlp_pkg.sv
sv/hrlp_front.sv
sv/hrlp_queue.sv
sv/hrlp_back.sv
sv/hsv_rgb_led_pulse_encoder.sv
tb/hsv_rgb_led_pulse_encoder_test.sv
